// File: sv/bfa_pkg.sv
`timescale 1ns / 1ps
package bfa_pkg;

  typedef enum logic [2:0] {
    OP_LOAD_AGE    = 3'd0,
    OP_LOAD_IN     = 3'd1,
    OP_LOAD_OUT    = 3'd2,
    OP_LOAD_SNAP   = 3'd3,
    OP_CLEAR       = 3'd4,
    OP_BURST       = 3'd5,
    OP_MERGE       = 3'd6,
    OP_READ        = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    CFG_MIN_ROW   = 2'd0,
    CFG_MAX_ROW   = 2'd1,
    CFG_ROWS      = 2'd2,
    CFG_CLEAR_VAL = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADDR,
    ST_FETCH,
    ST_MUL,
    ST_ACC,
    ST_READ,
    ST_OUT
  } be_state_t;

  localparam int unsigned ACC_W = 48;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam int unsigned MUL_SCALE = 1000;
  localparam int unsigned HALF_Q16 = 32768;

  // decoded command passed from front to back
  typedef struct packed {
    op_t         op;
    logic [15:0] address;
    logic [31:0] table_word;
    logic [6:0]  snap_target;
    logic [5:0]  snap_cloud_index;
    logic [5:0]  snapshot;
    logic [4:0]  zrow;
    logic [31:0] star_rate;
    logic [47:0] merge_value;
    logic        flux_kind;
  } cmd_t;

endpackage

// File: sv/bfa_front.sv
`timescale 1ns / 1ps
module bfa_front
  import bfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_address,
  input  logic [31:0] in_table_word,
  input  logic [6:0]  in_snap_target,
  input  logic [5:0]  in_snap_cloud_index,
  input  logic [5:0]  in_snapshot,
  input  logic [15:0] in_metal_fraction,
  input  logic [31:0] in_star_rate,
  input  logic [47:0] in_merge_value,
  input  logic        in_flux_kind,
  input  logic [3:0]  min_row,
  input  logic [3:0]  max_row,
  output logic        q_valid,
  input  logic        q_ready,
  output cmd_t        q_cmd
);
  // stage 1 register the raw word with the metal product, stage 2 clamp and queue
  logic        s1_valid_r, s1_valid_nxt;
  cmd_t        s1_cmd_r;
  logic [25:0] s1_t_r;
  logic [1:0]  cnt_r, cnt_nxt;
  cmd_t        fifo_r [2];
  logic        wp_r, rp_r;
  logic [4:0]  zc;
  logic [9:0]  zraw;
  cmd_t        ncmd;
  logic        push, pop;

  always_comb begin
    if (s1_t_r < 26'(HALF_Q16)) zraw = '0;
    else zraw = 10'((s1_t_r - 26'(HALF_Q16)) >> 16);
    if (zraw < ({6'd0, min_row} + 10'd1)) zc = {1'b0, min_row} + 5'd1;
    else if (zraw > {6'd0, max_row}) zc = {1'b0, max_row};
    else zc = zraw[4:0];
    ncmd = s1_cmd_r;
    ncmd.zrow = zc;
  end

  assign push = s1_valid_r && cnt_r != 2'd2;
  assign pop = q_valid && q_ready;
  assign in_ready = !s1_valid_r || push;
  assign q_valid = cnt_r != 2'd0;
  assign q_cmd = fifo_r[rp_r];

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (push) s1_valid_nxt = 1'b0;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r.op <= op_t'(in_operation);
      s1_cmd_r.address <= in_address;
      s1_cmd_r.table_word <= in_table_word;
      s1_cmd_r.snap_target <= in_snap_target;
      s1_cmd_r.snap_cloud_index <= in_snap_cloud_index;
      s1_cmd_r.snapshot <= in_snapshot;
      s1_cmd_r.zrow <= '0;
      s1_cmd_r.star_rate <= in_star_rate;
      s1_cmd_r.merge_value <= in_merge_value;
      s1_cmd_r.flux_kind <= in_flux_kind;
      s1_t_r <= 26'(in_metal_fraction * 26'(MUL_SCALE));
    end
    if (push) fifo_r[wp_r] <= ncmd;
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  a_nopop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop) else $error("pop empty");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !push) |=> s1_valid_r) else $error("stage dropped");
`endif
endmodule

// File: sv/bfa_back.sv
`timescale 1ns / 1ps
module bfa_back
  import bfa_pkg::*;
#(
  parameter int unsigned NUM_SNAPS = 4,
  parameter int unsigned NUM_BANDS = 16,
  parameter int unsigned MAX_AGE_STEPS = 64,
  parameter int unsigned MAX_METAL_ROWS = 16
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  input  logic [4:0]  metal_rows,
  input  logic [47:0] clear_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_flux_value,
  output logic        out_saturated
);
  localparam int unsigned ACC_D = NUM_SNAPS * NUM_BANDS;
  localparam int unsigned BC_D = ACC_D * MAX_METAL_ROWS;
  localparam int unsigned AGE_D = BC_D * MAX_AGE_STEPS;
  localparam int unsigned AW = $clog2(ACC_D) > 0 ? $clog2(ACC_D) : 1;
  localparam int unsigned BW = $clog2(BC_D) > 0 ? $clog2(BC_D) : 1;
  localparam int unsigned GW = $clog2(AGE_D);
  localparam int unsigned SW = $clog2(NUM_SNAPS) > 0 ? $clog2(NUM_SNAPS) : 1;
  localparam int unsigned FW = $clog2(NUM_BANDS) > 0 ? $clog2(NUM_BANDS) : 1;
  localparam int unsigned CW = $clog2(ACC_D + 1);

  logic [31:0] age_mem [AGE_D];
  logic [31:0] in_mem [BC_D];
  logic [31:0] out_mem [BC_D];
  logic [47:0] iacc_mem [ACC_D];
  logic [47:0] oacc_mem [ACC_D];
  logic [2*ACC_D-1:0] sat_r;
  logic [6:0]  steps_r [NUM_SNAPS];
  logic [5:0]  cidx_r [NUM_SNAPS];

  be_state_t st_r, st_nxt;
  cmd_t      cmd_r;
  logic [SW-1:0] s_r;
  logic [FW-1:0] f_r;
  logic [CW-1:0] clr_r;
  logic          init_r;
  logic [31:0]   base_r;
  logic [31:0]   ga_r;
  logic [BW-1:0] ba_r;
  logic          eq_r, gt_r, skip_r;
  logic [31:0]   ta_r, tb_r;
  logic [47:0]   ia_r, oa_r;
  logic [47:0]   pa_r, pb_r;
  logic [47:0]   ofv_r;
  logic          osat_r, ov_r;
  logic [AW-1:0] idx;
  logic          last_f, last_s;
  logic [7:0]    n8, a8;
  logic [31:0]   rowsb;
  logic          take;

  assign take = q_valid && q_ready;
  assign q_ready = st_r == ST_IDLE && !ov_r;
  assign out_valid = ov_r;
  assign out_flux_value = ofv_r;
  assign out_saturated = osat_r;
  assign idx = AW'(32'(s_r) * NUM_BANDS + 32'(f_r));
  assign last_f = 32'(f_r) == NUM_BANDS - 1;
  assign last_s = 32'(s_r) == NUM_SNAPS - 1;
  assign n8 = {1'b0, steps_r[s_r]};
  assign a8 = n8 - {2'b0, cmd_r.snapshot};
  assign rowsb = 32'(metal_rows) * NUM_BANDS;

  function automatic logic [48:0] sadd(input logic [47:0] x, input logic [47:0] y);
    sadd = {1'b0, x} + {1'b0, y};
  endfunction

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (take) begin
          case (q_cmd.op)
            OP_CLEAR: st_nxt = ST_CLEAR;
            OP_BURST: st_nxt = ST_ADDR;
            OP_MERGE, OP_READ: st_nxt = ST_READ;
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: if (32'(clr_r) == ACC_D - 1) st_nxt = ST_IDLE;
      ST_ADDR: st_nxt = ST_FETCH;
      ST_FETCH: st_nxt = skip_r ? (last_s ? ST_IDLE : ST_ADDR) : ST_MUL;
      ST_MUL: st_nxt = ST_ACC;
      ST_ACC: st_nxt = (last_f && last_s) ? ST_IDLE : ST_ADDR;
      ST_READ: st_nxt = (cmd_r.op == OP_READ) ? ST_OUT : ST_IDLE;
      ST_OUT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // zero every accumulator before the first word
      st_r <= ST_CLEAR;
      init_r <= 1'b1;
      ov_r <= 1'b0;
      sat_r <= '0;
      clr_r <= '0;
      s_r <= '0;
      f_r <= '0;
      base_r <= '0;
      for (int i = 0; i < NUM_SNAPS; i++) begin
        steps_r[i] <= '0;
        cidx_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          init_r <= 1'b0;
          clr_r <= '0;
          s_r <= '0;
          f_r <= '0;
          base_r <= '0;
          if (take && q_cmd.op == OP_LOAD_SNAP && 32'(q_cmd.address) < NUM_SNAPS) begin
            steps_r[SW'(q_cmd.address)] <= q_cmd.snap_target;
            cidx_r[SW'(q_cmd.address)] <= q_cmd.snap_cloud_index;
          end
          if (take && q_cmd.op == OP_CLEAR) sat_r <= '0;
        end
        ST_CLEAR: clr_r <= clr_r + 1'b1;
        ST_FETCH: begin
          if (skip_r) begin
            base_r <= base_r + 32'(n8) * rowsb;
            s_r <= s_r + 1'b1;
          end
        end
        ST_ACC: begin
          if (!eq_r && !gt_r) begin
            if (sadd(ia_r, pa_r) > 49'(ACC_MAX)) sat_r[idx] <= 1'b1;
          end
          if (eq_r) begin
            if (sadd(ia_r, pa_r) > 49'(ACC_MAX)) sat_r[idx] <= 1'b1;
          end
          if (eq_r || gt_r) begin
            if (sadd(oa_r, eq_r ? pb_r : pa_r) > 49'(ACC_MAX)) sat_r[ACC_D + idx] <= 1'b1;
          end
          f_r <= f_r + 1'b1;
          if (last_f) begin
            f_r <= '0;
            s_r <= s_r + 1'b1;
            base_r <= base_r + 32'(n8) * rowsb;
          end
        end
        ST_READ: begin
          if (cmd_r.op == OP_MERGE && 32'(cmd_r.address) < ACC_D) begin
            if (sadd(cmd_r.flux_kind ? oa_r : ia_r, cmd_r.merge_value) > 49'(ACC_MAX))
              sat_r[{cmd_r.flux_kind, AW'(cmd_r.address)}] <= 1'b1;
          end
        end
        ST_OUT: begin
          ov_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath and memories
  always_ff @(posedge clk) begin
    if (take) cmd_r <= q_cmd;
    if (take && q_cmd.op == OP_LOAD_AGE && 32'(q_cmd.address) < AGE_D)
      age_mem[GW'(q_cmd.address)] <= q_cmd.table_word;
    if (take && q_cmd.op == OP_LOAD_IN && 32'(q_cmd.address) < BC_D)
      in_mem[BW'(q_cmd.address)] <= q_cmd.table_word;
    if (take && q_cmd.op == OP_LOAD_OUT && 32'(q_cmd.address) < BC_D)
      out_mem[BW'(q_cmd.address)] <= q_cmd.table_word;
    if (st_r == ST_CLEAR) begin
      iacc_mem[AW'(clr_r)] <= init_r ? '0 : clear_value;
      oacc_mem[AW'(clr_r)] <= init_r ? '0 : clear_value;
    end
    if (st_r == ST_ADDR) begin
      skip_r <= n8 < {2'b0, cmd_r.snapshot};
      eq_r <= {2'b0, cidx_r[s_r]} == a8;
      gt_r <= a8 > {2'b0, cidx_r[s_r]};
      ga_r <= base_r + ((32'(cmd_r.zrow) * 32'(n8) + 32'(a8)) * NUM_BANDS) + 32'(f_r);
      ba_r <= BW'(32'(s_r) * rowsb + 32'(cmd_r.zrow) * NUM_BANDS + 32'(f_r));
    end
    if (st_r == ST_FETCH) begin
      ta_r <= eq_r ? in_mem[ba_r] : age_mem[GW'(ga_r)];
      tb_r <= out_mem[ba_r];
      ia_r <= iacc_mem[idx];
      oa_r <= oacc_mem[idx];
    end
    if (st_r == ST_MUL) begin
      pa_r <= 48'((64'(cmd_r.star_rate) * 64'(ta_r)) >> 16);
      pb_r <= 48'((64'(cmd_r.star_rate) * 64'(tb_r)) >> 16);
    end
    if (st_r == ST_ACC) begin
      if (eq_r || !gt_r) begin
        iacc_mem[idx] <= (sadd(ia_r, pa_r) > 49'(ACC_MAX)) ? ACC_MAX
                         : 48'(sadd(ia_r, pa_r));
      end
      if (eq_r || gt_r) begin
        oacc_mem[idx] <= (sadd(oa_r, eq_r ? pb_r : pa_r) > 49'(ACC_MAX)) ? ACC_MAX
                         : 48'(sadd(oa_r, eq_r ? pb_r : pa_r));
      end
    end
    if (take) begin
      ia_r <= iacc_mem[AW'(q_cmd.address)];
      oa_r <= oacc_mem[AW'(q_cmd.address)];
    end
    if (st_r == ST_READ) begin
      if (cmd_r.op == OP_MERGE && 32'(cmd_r.address) < ACC_D) begin
        if (cmd_r.flux_kind)
          oacc_mem[AW'(cmd_r.address)] <= (sadd(oa_r, cmd_r.merge_value) > 49'(ACC_MAX))
            ? ACC_MAX : 48'(sadd(oa_r, cmd_r.merge_value));
        else
          iacc_mem[AW'(cmd_r.address)] <= (sadd(ia_r, cmd_r.merge_value) > 49'(ACC_MAX))
            ? ACC_MAX : 48'(sadd(ia_r, cmd_r.merge_value));
      end
      if (32'(cmd_r.address) < ACC_D) begin
        ofv_r <= cmd_r.flux_kind ? oa_r : ia_r;
        osat_r <= sat_r[{cmd_r.flux_kind, AW'(cmd_r.address)}];
      end else begin
        ofv_r <= '0;
        osat_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !q_ready) else $error("took word while busy");
  a_out_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r) == ST_OUT) else $error("stray result");
  a_clear_flags: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CLEAR |-> sat_r == '0) else $error("flags during clear");
`endif
endmodule

// File: sv/burst_flux_accumulator_top.sv
`timescale 1ns / 1ps
// Burst flux accumulator.
// Input channel in_*: valid/ready words carrying one operation each
// (table load, snapshot load, clear, burst, merge add, read).
// Output channel out_*: valid/ready, one word per read operation.
// Config port cfg_*: write enable, index, data; write only while idle.
// A front stage computes the metallicity row (one multiply, one clamp) and
// pushes into a two-entry queue; the back sequencer executes each word.
// Each word is executed to completion before the next one is taken.
// A clear rewrites every accumulator entry; a burst visits each band of
// every active snapshot in turn (address, fetch, multiply, accumulate).
// Reset clears control state, snapshot entries and saturation flags, then
// zeroes the accumulators before taking words.
// Template tables are undefined until loaded.
// While out_ready is low a read result is held and the back end stalls;
// the queue then fills and in_ready falls.
module burst_flux_accumulator_top
  import bfa_pkg::*;
#(
  parameter int unsigned NUM_SNAPS = 4,
  parameter int unsigned NUM_BANDS = 16,
  parameter int unsigned MAX_AGE_STEPS = 64,
  parameter int unsigned MAX_METAL_ROWS = 16
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_address,
  input  logic [31:0] in_table_word,
  input  logic [6:0]  in_snap_target,
  input  logic [5:0]  in_snap_cloud_index,
  input  logic [5:0]  in_snapshot,
  input  logic [15:0] in_metal_fraction,
  input  logic [31:0] in_star_rate,
  input  logic [47:0] in_merge_value,
  input  logic        in_flux_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_flux_value,
  output logic        out_saturated,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  logic [3:0]  min_row_r, max_row_r;
  logic [4:0]  rows_r;
  logic [47:0] clr_val_r;
  logic        q_valid, q_ready;
  cmd_t        q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_row_r <= 4'd0;
      max_row_r <= 4'd15;
      rows_r <= 5'd16;
      clr_val_r <= 48'd1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_ROW: min_row_r <= cfg_data[3:0];
        CFG_MAX_ROW: max_row_r <= cfg_data[3:0];
        CFG_ROWS: rows_r <= cfg_data[4:0];
        CFG_CLEAR_VAL: clr_val_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bfa_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_address, .in_table_word,
    .in_snap_target, .in_snap_cloud_index, .in_snapshot, .in_metal_fraction,
    .in_star_rate, .in_merge_value, .in_flux_kind,
    .min_row(min_row_r), .max_row(max_row_r),
    .q_valid, .q_ready, .q_cmd
  );

  bfa_back #(
    .NUM_SNAPS(NUM_SNAPS), .NUM_BANDS(NUM_BANDS),
    .MAX_AGE_STEPS(MAX_AGE_STEPS), .MAX_METAL_ROWS(MAX_METAL_ROWS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .metal_rows(rows_r), .clear_value(clr_val_r),
    .out_valid, .out_ready, .out_flux_value, .out_saturated
  );
endmodule
